/* rtl/core/haplotype_label_builder_defines.svh */
// Assertion macros used by the checker file.
`ifndef HAPLOTYPE_LABEL_BUILDER_DEFINES_SVH
`define HAPLOTYPE_LABEL_BUILDER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define HLB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HLB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/hlb_pkg.sv */
// Shared constants for the haplotype label builder.
package hlb_pkg;
	localparam int LABEL_W = 20;
	localparam int LEAF_W = 21;
	localparam int DENSE_W = 12;
	localparam int CODE_W = 13;
	localparam int KEY_DEPTH = 1 << LABEL_W;
	localparam int DEF_SAMPLE_COUNT = 1024;
	localparam int DEF_MAX_LEAVES = 65536;
	localparam int IN_W = 24;
	localparam int OUT_W = 64;
	localparam int OUT_USED_W = 2 * LABEL_W + LEAF_W;
	localparam int PADDR_W = 3;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_NEW_WINDOW = 2'd2;

	localparam logic [PADDR_W-1:0] REG_COLLAPSE = 3'd0;
	localparam logic [LEAF_W-1:0] LEAF_SAT = {LEAF_W{1'b1}};
	localparam logic [CODE_W-1:0] CODE_EMPTY = '0;
	localparam logic [CODE_W-1:0] CODE_MISSING = 13'd1;
endpackage

/* rtl/core/hlb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/haplotype_label_builder.sv */
// Haplotype label builder: per-sample label RAM, key map RAM, relabel sequencer.
// Update: label RAM read, then modify and write back.
// Read: label RAM read, then S_RD loads the output register once it is free; new window and unused commands pass S_GAP.
// Relabel after a leaf count overflow walks the label RAM
// three times (clear keys, map keys, finalize) through the key map RAM.
// Reset: control, leaf count (1) and collapse_missing (1) clear; RAM contents are undefined.
module haplotype_label_builder #(
	parameter int SAMPLE_COUNT = hlb_pkg::DEF_SAMPLE_COUNT,
	parameter int MAX_LEAVES = hlb_pkg::DEF_MAX_LEAVES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd, sample_index, left code, right code, num_alleles
	input  logic [hlb_pkg::IN_W-1:0]     s_tdata,
	input  logic                         s_tlast,   // last_sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// left_label, right_label, leaf_count, zero fill
	output logic [hlb_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hlb_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import hlb_pkg::*;

	localparam int SW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam logic [SW:0] LAST_IDX = (SW + 1)'(SAMPLE_COUNT - 1);
	localparam logic [24:0] MAX_L = 25'(MAX_LEAVES);

	typedef enum logic [3:0] {
		S_IDLE, S_GAP, S_UPD, S_RD,
		S_CA_RD, S_CA_L, S_CA_R, S_TOP,
		S_MB_RD, S_MB_L, S_MB_LW, S_MB_R, S_MB_RW,
		S_FC_RD, S_FC_W
	} state_t;

	state_t               state_q;
	logic [SW-1:0]        idx_q;
	logic                 inr_q;
	logic [3:0]           la_q, ra_q, na_q;
	logic                 last_q;
	logic [SW:0]          cnt_q;
	logic [CODE_W-1:0]    codel_q;
	logic [LEAF_W-1:0]    leaves_q;
	logic [DENSE_W-1:0]   next_q;
	logic                 collapse_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     out_q;

	logic                 accept;
	logic [SW-1:0]        in_idx;
	logic                 smp_we, smp_re;
	logic [SW-1:0]        smp_waddr, smp_raddr;
	logic [2*LABEL_W-1:0] smp_wdata, smp_rdata;
	logic                 map_we, map_re;
	logic [LABEL_W-1:0]   map_waddr, map_raddr;
	logic [CODE_W-1:0]    map_wdata, map_rdata;
	logic [LABEL_W-1:0]   dl, dr, top_key;
	logic                 map_hit;
	logic [CODE_W-1:0]    code;
	logic [4:0]           radix;
	logic [24:0]          prod_l, prod_r;
	logic [25:0]          leaf_prod;
	logic [LEAF_W-1:0]    leaf_new;
	logic [LABEL_W-1:0]   new_l, new_r, all_miss;
	logic                 miss_in;
	logic                 relabel;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign in_idx = SW'(s_tdata[11:2]);
	assign dl = smp_rdata[LABEL_W-1:0];
	assign dr = smp_rdata[2*LABEL_W-1:LABEL_W];
	assign top_key = LABEL_W'(leaves_q - 1'b1);
	assign map_hit = (map_rdata != CODE_EMPTY);
	assign code = map_hit ? map_rdata : (CODE_W'(next_q) + CODE_W'(2));

	// update arithmetic on the label pair just read
	assign radix = {1'b0, na_q} + 5'd1;
	assign prod_l = 25'(dl * radix);
	assign prod_r = 25'(dr * radix);
	assign leaf_prod = 26'(leaves_q * radix);
	assign leaf_new = (leaf_prod > 26'(LEAF_SAT)) ? LEAF_SAT : LEAF_W'(leaf_prod);
	assign all_miss = LABEL_W'(leaf_prod - 26'd1);
	assign miss_in = (la_q == na_q) || (ra_q == na_q);
	assign relabel = last_q && ({4'b0, leaf_new} >= MAX_L);

	always_comb begin
		if (leaves_q == LEAF_W'(1)) begin
			if (collapse_q && miss_in) begin
				new_l = LABEL_W'(na_q);
				new_r = LABEL_W'(na_q);
			end else begin
				new_l = LABEL_W'(la_q);
				new_r = LABEL_W'(ra_q);
			end
		end else if (collapse_q && (dl == top_key || dr == top_key || miss_in)) begin
			new_l = all_miss;
			new_r = all_miss;
		end else begin
			new_l = LABEL_W'(prod_l + 25'(la_q));
			new_r = LABEL_W'(prod_r + 25'(ra_q));
		end
	end

	// RAM port control
	always_comb begin
		smp_re = 1'b0;
		smp_raddr = cnt_q[SW-1:0];
		smp_we = 1'b0;
		smp_waddr = cnt_q[SW-1:0];
		smp_wdata = {new_r, new_l};
		map_re = 1'b0;
		map_raddr = dl;
		map_we = 1'b0;
		map_waddr = dl;
		map_wdata = CODE_EMPTY;
		unique case (state_q)
			S_IDLE: begin
				smp_re = accept;
				smp_raddr = in_idx;
			end
			S_UPD: begin
				smp_we = inr_q;
				smp_waddr = idx_q;
			end
			S_CA_RD, S_MB_RD, S_FC_RD: smp_re = 1'b1;
			S_CA_L: map_we = 1'b1;
			S_CA_R: begin
				map_we = 1'b1;
				map_waddr = dr;
			end
			S_TOP: begin
				map_we = 1'b1;
				map_waddr = top_key;
				map_wdata = CODE_MISSING;
			end
			S_MB_L: map_re = 1'b1;
			S_MB_LW: begin
				map_we = !map_hit;
				map_wdata = code;
			end
			S_MB_R: begin
				map_re = 1'b1;
				map_raddr = dr;
			end
			S_MB_RW: begin
				map_we = !map_hit;
				map_waddr = dr;
				map_wdata = code;
				smp_we = 1'b1;
				smp_wdata = {LABEL_W'(code), LABEL_W'(codel_q)};
			end
			S_FC_W: begin
				smp_we = 1'b1;
				smp_wdata[LABEL_W-1:0] = (dl == LABEL_W'(1)) ? LABEL_W'(next_q) : dl - 2'd2;
				smp_wdata[2*LABEL_W-1:LABEL_W] =
					(dr == LABEL_W'(1)) ? LABEL_W'(next_q) : dr - 2'd2;
			end
			default: ;
		endcase
	end

	hlb_ram #(.WIDTH(2 * LABEL_W), .DEPTH(SAMPLE_COUNT), .AW(SW)) u_label_ram (
		.clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
		.re(smp_re), .raddr(smp_raddr), .rdata(smp_rdata)
	);

	hlb_ram #(.WIDTH(CODE_W), .DEPTH(KEY_DEPTH), .AW(LABEL_W)) u_key_ram (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			leaves_q <= LEAF_W'(1);
			next_q <= '0;
			collapse_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_COLLAPSE) begin
				collapse_q <= pwdata[0];
			end
			// S_RD owns the output valid while it loads a result
			if (m_tready && state_q != S_RD) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= in_idx;
						inr_q <= (32'(s_tdata[11:2]) < SAMPLE_COUNT);
						la_q <= s_tdata[15:12];
						ra_q <= s_tdata[19:16];
						na_q <= s_tdata[23:20];
						last_q <= s_tlast;
						unique case (s_tdata[1:0])
							CMD_UPDATE: state_q <= S_UPD;
							CMD_READ: state_q <= S_RD;
							CMD_NEW_WINDOW: begin
								leaves_q <= LEAF_W'(1);
								state_q <= S_GAP;
							end
							default: state_q <= S_GAP;
						endcase
					end
				end
				S_GAP: state_q <= S_IDLE;
				S_UPD: begin
					if (last_q) begin
						leaves_q <= leaf_new;
					end
					cnt_q <= '0;
					state_q <= relabel ? S_CA_RD : S_IDLE;
				end
				S_RD: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_q <= {{(OUT_W - OUT_USED_W){1'b0}}, leaves_q,
							inr_q ? dr : LABEL_W'(0), inr_q ? dl : LABEL_W'(0)};
						state_q <= S_IDLE;
					end
				end
				S_CA_RD: state_q <= S_CA_L;
				S_CA_L: state_q <= S_CA_R;
				S_CA_R: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						state_q <= S_TOP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_CA_RD;
					end
				end
				S_TOP: begin
					next_q <= '0;
					state_q <= S_MB_RD;
				end
				S_MB_RD: state_q <= S_MB_L;
				S_MB_L: state_q <= S_MB_LW;
				S_MB_LW: begin
					codel_q <= code;
					if (!map_hit) begin
						next_q <= next_q + 1'b1;
					end
					state_q <= S_MB_R;
				end
				S_MB_R: state_q <= S_MB_RW;
				S_MB_RW: begin
					if (!map_hit) begin
						next_q <= next_q + 1'b1;
					end
					if (cnt_q == LAST_IDX) begin
						cnt_q <= '0;
						state_q <= S_FC_RD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_MB_RD;
					end
				end
				S_FC_RD: state_q <= S_FC_W;
				S_FC_W: begin
					if (cnt_q == LAST_IDX) begin
						leaves_q <= LEAF_W'(next_q) + 1'b1;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_FC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_COLLAPSE) ? {31'b0, collapse_q} : 32'b0;
endmodule

/* rtl/core/hlb_checker.sv */
// Port-level checker for the haplotype label builder, bound to the top level.
`include "haplotype_label_builder_defines.svh"

module hlb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [hlb_pkg::OUT_W-1:0]    m_tdata
);
	import hlb_pkg::*;

	`HLB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`HLB_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
	`HLB_ASSERT_NOW(a_leaf_nonzero, m_tvalid, m_tdata[OUT_USED_W-1:2*LABEL_W] != '0)
	`HLB_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_W-1:OUT_USED_W] == '0)
endmodule

bind haplotype_label_builder hlb_checker u_hlb_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
